// ----- design/lcst_pkg.sv -----
`timescale 1ns / 1ps

package lcst_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_SEND_BYTE = 2'd1;
    localparam logic [1:0] CMD_FILL      = 2'd2;
    localparam logic [1:0] CMD_FILL_ZERO = 2'd3;

    // register indexes of the write port
    localparam logic [2:0] REG_HALF_BIT_TICKS = 3'd0;
    localparam logic [2:0] REG_LATCH_TICKS    = 3'd1;
    localparam logic [2:0] REG_STRIP_LENGTH   = 3'd2;
    localparam logic [2:0] REG_RED_LEVEL      = 3'd3;
    localparam logic [2:0] REG_GREEN_LEVEL    = 3'd4;
    localparam logic [2:0] REG_BLUE_LEVEL     = 3'd5;

    localparam int REG_INDEX_W = 3;
    localparam int REG_DATA_W  = 16;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       latch_after;
    } lcst_item_t;

    typedef struct packed {
        logic clock_pin;
        logic data_pin;
        logic busy_res;
        logic rejected;
    } lcst_result_t;

    typedef struct packed {
        logic                   wr_en;
        logic [REG_INDEX_W-1:0] wr_index;
        logic [REG_DATA_W-1:0]  wr_data;
    } lcst_cfg_wr_t;

endpackage

// ----- design/lcst_in_if.sv -----
`timescale 1ns / 1ps

interface lcst_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       latch_after;

    modport source (output valid, output command, output data_byte, output latch_after,
                    input ready);
    modport sink (input valid, input command, input data_byte, input latch_after,
                  output ready);
endinterface

// ----- design/lcst_out_if.sv -----
`timescale 1ns / 1ps

interface lcst_out_if;
    logic valid;
    logic ready;
    logic clock_pin;
    logic data_pin;
    logic busy_res;
    logic rejected;

    modport source (output valid, output clock_pin, output data_pin, output busy_res,
                    output rejected, input ready);
    modport sink (input valid, input clock_pin, input data_pin, input busy_res,
                  input rejected, output ready);
endinterface

// ----- design/lcst_engine.sv -----
`timescale 1ns / 1ps

module lcst_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  lcst_pkg::lcst_item_t   item,
    input  lcst_pkg::lcst_cfg_wr_t cfg,
    output lcst_pkg::lcst_result_t result
);
    import lcst_pkg::*;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_SEND  = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;
    localparam logic [1:0] MODE_LATCH = 2'd3;

    logic [15:0] half_bit_ticks_reg;
    logic [15:0] latch_ticks_reg;
    logic [9:0]  strip_length_reg;
    logic [7:0]  red_level_reg;
    logic [7:0]  green_level_reg;
    logic [7:0]  blue_level_reg;

    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic        phase_high_reg, phase_high_next;
    logic [15:0] phase_counter_reg, phase_counter_next;
    logic [15:0] latch_counter_reg, latch_counter_next;
    logic [9:0]  led_counter_reg, led_counter_next;
    logic [1:0]  colour_index_reg, colour_index_next;
    logic [1:0]  mode_reg, mode_next;
    logic        latch_pending_reg, latch_pending_next;
    logic        fill_zero_reg, fill_zero_next;

    // colour byte for one position of an led
    function automatic logic [7:0] colour_byte(input logic zero, input logic [1:0] idx,
                                               input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        logic [7:0] value;
        if (zero)
            value = 8'd0;
        else if (idx == 2'd0)
            value = r;
        else if (idx == 2'd1)
            value = g;
        else
            value = b;
        return value;
    endfunction

    // one tick of the waveform: command start, bit timing, latch wait
    always_comb
    begin
        shift_byte_next    = shift_byte_reg;
        bit_index_next     = bit_index_reg;
        phase_high_next    = phase_high_reg;
        phase_counter_next = phase_counter_reg;
        latch_counter_next = latch_counter_reg;
        led_counter_next   = led_counter_reg;
        colour_index_next  = colour_index_reg;
        mode_next          = mode_reg;
        latch_pending_next = latch_pending_reg;
        fill_zero_next     = fill_zero_reg;
        result             = '0;

        if (item.command != CMD_TICK)
        begin
            if (mode_reg != MODE_IDLE)
            begin
                result.rejected = 1'b1;
            end
            else if (item.command == CMD_SEND_BYTE)
            begin
                mode_next          = MODE_SEND;
                latch_pending_next = item.latch_after;
                shift_byte_next    = item.data_byte;
                bit_index_next     = 3'd7;
                phase_high_next    = 1'b0;
                phase_counter_next = 16'd0;
            end
            else
            begin
                mode_next          = MODE_FILL;
                latch_pending_next = 1'b1;
                fill_zero_next     = (item.command == CMD_FILL_ZERO);
                led_counter_next   = 10'd0;
                colour_index_next  = 2'd0;
                shift_byte_next    = colour_byte(fill_zero_next, 2'd0, red_level_reg,
                                                 green_level_reg, blue_level_reg);
                bit_index_next     = 3'd7;
                phase_high_next    = 1'b0;
                phase_counter_next = 16'd0;
            end
        end

        if (mode_next == MODE_SEND || mode_next == MODE_FILL)
        begin
            result.busy_res    = 1'b1;
            result.clock_pin   = phase_high_next;
            result.data_pin    = shift_byte_next[bit_index_next];
            phase_counter_next = phase_counter_next + 16'd1;
            if (phase_counter_next >= half_bit_ticks_reg)
            begin
                phase_counter_next = 16'd0;
                if (!phase_high_next)
                begin
                    phase_high_next = 1'b1;
                end
                else
                begin
                    phase_high_next = 1'b0;
                    if (bit_index_next != 3'd0)
                    begin
                        bit_index_next = bit_index_next - 3'd1;
                    end
                    else if (mode_next == MODE_SEND)
                    begin
                        bit_index_next     = 3'd7;
                        mode_next          = latch_pending_next ? MODE_LATCH : MODE_IDLE;
                        latch_counter_next = latch_pending_next ? 16'd0 : latch_counter_next;
                        latch_pending_next = 1'b0;
                    end
                    else
                    begin
                        // next colour byte, or next led after blue
                        colour_index_next = colour_index_next + 2'd1;
                        if (colour_index_next == 2'd3)
                        begin
                            colour_index_next = 2'd0;
                            led_counter_next  = led_counter_next + 10'd1;
                        end
                        if (colour_index_next == 2'd0 && led_counter_next >= strip_length_reg)
                        begin
                            bit_index_next     = 3'd7;
                            mode_next          = latch_pending_next ? MODE_LATCH : MODE_IDLE;
                            latch_counter_next = latch_pending_next ? 16'd0
                                                                    : latch_counter_next;
                            latch_pending_next = 1'b0;
                        end
                        else
                        begin
                            shift_byte_next    = colour_byte(fill_zero_next, colour_index_next,
                                                             red_level_reg, green_level_reg,
                                                             blue_level_reg);
                            bit_index_next     = 3'd7;
                            phase_high_next    = 1'b0;
                            phase_counter_next = 16'd0;
                        end
                    end
                end
            end
        end
        else if (mode_next == MODE_LATCH)
        begin
            result.busy_res    = 1'b1;
            latch_counter_next = latch_counter_next + 16'd1;
            if (latch_counter_next >= latch_ticks_reg)
            begin
                latch_counter_next = 16'd0;
                mode_next          = MODE_IDLE;
            end
        end
    end

    // job state, stepped once per processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_byte_reg    <= 8'd0;
            bit_index_reg     <= 3'd7;
            phase_high_reg    <= 1'b0;
            phase_counter_reg <= 16'd0;
            latch_counter_reg <= 16'd0;
            led_counter_reg   <= 10'd0;
            colour_index_reg  <= 2'd0;
            mode_reg          <= MODE_IDLE;
            latch_pending_reg <= 1'b0;
            fill_zero_reg     <= 1'b0;
        end
        else if (advance)
        begin
            shift_byte_reg    <= shift_byte_next;
            bit_index_reg     <= bit_index_next;
            phase_high_reg    <= phase_high_next;
            phase_counter_reg <= phase_counter_next;
            latch_counter_reg <= latch_counter_next;
            led_counter_reg   <= led_counter_next;
            colour_index_reg  <= colour_index_next;
            mode_reg          <= mode_next;
            latch_pending_reg <= latch_pending_next;
            fill_zero_reg     <= fill_zero_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_ticks_reg <= 16'd10;
            latch_ticks_reg    <= 16'd2000;
            strip_length_reg   <= 10'd32;
            red_level_reg      <= 8'd0;
            green_level_reg    <= 8'd0;
            blue_level_reg     <= 8'd0;
        end
        else if (cfg.wr_en)
        begin
            unique case (cfg.wr_index)
                REG_HALF_BIT_TICKS: half_bit_ticks_reg <= cfg.wr_data;
                REG_LATCH_TICKS:    latch_ticks_reg    <= cfg.wr_data;
                REG_STRIP_LENGTH:   strip_length_reg   <= cfg.wr_data[9:0];
                REG_RED_LEVEL:      red_level_reg      <= cfg.wr_data[7:0];
                REG_GREEN_LEVEL:    green_level_reg    <= cfg.wr_data[7:0];
                REG_BLUE_LEVEL:     blue_level_reg     <= cfg.wr_data[7:0];
                default:            ;
            endcase
        end
    end

endmodule

// ----- design/led_chain_serial_transmitter.sv -----
`timescale 1ns / 1ps

// LED chain clock/data driver.
// item channel: one beat per time tick; command is tick, send byte (data_byte,
// latch_after), colour fill or zero fill. result channel: one beat per item
// with the clock and data pin levels for that tick, busy_res and rejected.
// An accepted item is held in the input register; its result is registered in the
// output register. Throughput is one item per cycle while the receiver takes results;
// the state update is a single pass of logic between the input register and
// the output register, bounded by the 16-bit phase and latch compares.
// The input register is taken again while the output register is drained,
// so a beat enters every cycle as long as the receiver takes results.
// When the receiver stalls, the held result stays put, the job state does
// not advance and item ready drops once the input register is also full.
// Reset clears both registers, sets the job state idle and restores the
// configuration registers to their defaults. The user must write registers through
// wr_en / wr_index / wr_data only while the block is idle; this is not enforced.
module led_chain_serial_transmitter (
    input  logic                               clk,
    input  logic                               rst_n,
    lcst_in_if.sink                            item,
    lcst_out_if.source                         result,
    input  logic                               wr_en,
    input  logic [lcst_pkg::REG_INDEX_W-1:0]   wr_index,
    input  logic [lcst_pkg::REG_DATA_W-1:0]    wr_data
);
    import lcst_pkg::*;

    logic         in_valid_reg;
    lcst_item_t   in_item_reg;
    logic         out_valid_reg;
    lcst_result_t out_result_reg;
    lcst_result_t step_result;
    lcst_cfg_wr_t cfg;
    logic         advance;

    assign cfg.wr_en    = wr_en;
    assign cfg.wr_index = wr_index;
    assign cfg.wr_data  = wr_data;

    // process the held beat when the output register is free or drained
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_item_reg.command     <= item.command;
            in_item_reg.data_byte   <= item.data_byte;
            in_item_reg.latch_after <= item.latch_after;
        end
    end

    lcst_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= step_result;
    end

    assign result.valid     = out_valid_reg;
    assign result.clock_pin = out_result_reg.clock_pin;
    assign result.data_pin  = out_result_reg.data_pin;
    assign result.busy_res  = out_result_reg.busy_res;
    assign result.rejected  = out_result_reg.rejected;

    // checks
    a_idle_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_result_reg.busy_res |->
            !out_result_reg.clock_pin && !out_result_reg.data_pin)
        else $error("pins active while not busy");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.rejected |-> out_result_reg.busy_res)
        else $error("rejected flagged while idle");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |-> !in_valid_reg || advance)
        else $error("input register overwritten");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed beat lost");

endmodule
